/* hdl/gbai_pkg.sv */
// ============================================================================
// gbai_pkg - gyro bias / angle integrator shared definitions
// Item types, field widths, command and register codes, bias reciprocal.
// ============================================================================
package gbai_pkg;

    // number of calibration samples averaged into one bias
    localparam int CAL_SAMPLES = 2000;
    localparam int CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);

    localparam int AXES       = 3;
    localparam int RATE_W     = 16;
    localparam int BIAS_FRAC  = 8;                    // bias is Q.8
    localparam int BIAS_W     = RATE_W + BIAS_FRAC;   // 24
    localparam int SUM_W      = 27;
    localparam int DIFF_W     = BIAS_W + 1;           // sample*256 - bias
    localparam int SCALE_W    = 32;
    localparam int THR_W      = 24;
    localparam int PROD_W     = DIFF_W + SCALE_W;     // 57, signed
    localparam int INC_SHIFT  = 16;
    localparam int INC_W      = PROD_W - INC_SHIFT;   // 41, signed
    localparam int ANGLE_W    = 40;

    // bias = trunc(|sum| * 256 / CAL_SAMPLES) by reciprocal multiply.
    // Exact for |sum| <= 2^(SUM_W-1) with this shift.
    localparam int RECIP_SHIFT = SUM_W - 1 + CAL_CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT + BIAS_FRAC + 1;
    localparam int RECIP_LO_W  = RECIP_W / 2;
    localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << (RECIP_SHIFT + BIAS_FRAC)) + 64'(CAL_SAMPLES) - 64'd1)
        / 64'(CAL_SAMPLES);
    localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_LO_W'(RECIP);
    localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_HI_W'(RECIP >> RECIP_LO_W);
    localparam int PP_W   = SUM_W + RECIP_LO_W;
    localparam int PPH_W  = SUM_W + RECIP_HI_W;
    localparam int QSUM_W = RECIP_SHIFT + BIAS_W;

    // commands
    localparam logic CMD_CAL   = 1'b0;
    localparam logic CMD_INTEG = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 1'b1;
    localparam logic [SCALE_W-1:0]   RATE_SCALE_RST     = 32'd261888;
    localparam logic [THR_W-1:0]     HOLD_THRESHOLD_RST = 24'd33554;

    typedef struct packed {
        logic                     command;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } t_in_item;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_x_out;
        logic signed [ANGLE_W-1:0] angle_y_out;
        logic signed [ANGLE_W-1:0] angle_z_out;
        logic                      calibration_done;
    } t_out_item;

    // calibration unit status toward the pipeline
    typedef struct packed {
        logic busy;   // bias divider running, hold the input stage
        logic done;   // item in the input stage completes calibration
    } t_cal_stat;

    // control carried alongside the products
    typedef struct packed {
        logic cmd;
        logic done;
    } t_s2_ctl;

endpackage

/* hdl/gbai_cal.sv */
// ============================================================================
// gbai_cal - calibration sums and bias divider
// Per-axis sums, sample count, and a reciprocal-multiply divider (magnitude
// register, then partial-product registers) that turns the final sums into Q.8 biases.
// ============================================================================
module gbai_cal (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  logic signed [gbai_pkg::RATE_W-1:0] i_rate [gbai_pkg::AXES],
    output gbai_pkg::t_cal_stat             o_stat,
    output logic signed [gbai_pkg::BIAS_W-1:0] o_bias [gbai_pkg::AXES]
);
    import gbai_pkg::*;

    logic signed [SUM_W-1:0]  r_sum [AXES];
    logic signed [SUM_W-1:0]  n_sum [AXES];
    logic [CAL_CNT_W-1:0]     r_count;
    logic [CAL_CNT_W-1:0]     cnt_inc;
    logic                     last;

    logic                     r_bp_a;
    logic                     r_bp_b;
    logic [SUM_W-1:0]         r_mag   [AXES];
    logic                     r_neg_a [AXES];
    logic                     r_neg_b [AXES];
    logic [PP_W-1:0]          r_pp_lo [AXES];
    logic [PPH_W-1:0]         r_pp_hi [AXES];
    logic signed [BIAS_W-1:0] r_bias  [AXES];

    logic [SUM_W-1:0]         mag     [AXES];
    logic [QSUM_W-1:0]        qsum    [AXES];
    logic [BIAS_W-1:0]        q       [AXES];

    always_comb begin
        cnt_inc = r_count + CAL_CNT_W'(1);
        last    = (cnt_inc >= CAL_CNT_W'(CAL_SAMPLES));
        for (int i = 0; i < AXES; i++) begin
            n_sum[i] = r_sum[i] + {{(SUM_W-RATE_W){i_rate[i][RATE_W-1]}}, i_rate[i]};
            mag[i]   = n_sum[i][SUM_W-1] ? SUM_W'(-n_sum[i]) : SUM_W'(n_sum[i]);
            qsum[i]  = QSUM_W'({r_pp_hi[i], {RECIP_LO_W{1'b0}}})
                     + QSUM_W'(r_pp_lo[i]);
            q[i]     = qsum[i][QSUM_W-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bp_a  <= 1'b0;
            r_bp_b  <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
        end else begin
            r_bp_a <= i_take && last;
            r_bp_b <= r_bp_a;
            if (i_take) begin
                if (last) begin
                    r_count <= '0;
                    for (int i = 0; i < AXES; i++) begin
                        r_sum[i] <= '0;
                    end
                end else begin
                    r_count <= cnt_inc;
                    for (int i = 0; i < AXES; i++) begin
                        r_sum[i] <= n_sum[i];
                    end
                end
            end
            if (r_bp_b) begin
                for (int i = 0; i < AXES; i++) begin
                    r_bias[i] <= r_neg_b[i] ? -q[i] : q[i];
                end
            end
        end
    end

    // divider datapath, no reset needed
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < AXES; i++) begin
            if (i_take && last) begin
                r_mag[i]   <= mag[i];
                r_neg_a[i] <= n_sum[i][SUM_W-1];
            end
            r_pp_lo[i] <= r_mag[i] * RECIP_LO;
            r_pp_hi[i] <= r_mag[i] * RECIP_HI;
            r_neg_b[i] <= r_neg_a[i];
        end
    end

    assign o_stat.busy = r_bp_a | r_bp_b;
    assign o_stat.done = i_take && last;
    assign o_bias      = r_bias;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CAL_CNT_W'(CAL_SAMPLES))
        else $error("calibration count reached its limit without wrapping");

    a_div_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && last) |=> (r_bp_a && !r_bp_b) ##1 (r_bp_b && !r_bp_a))
        else $error("bias divider sequence broken");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp_a || r_bp_b) |-> !i_take)
        else $error("calibration item taken while bias divider busy");

endmodule

/* hdl/gbai_rmul.sv */
// ============================================================================
// gbai_rmul - bias removal and rate scaling stage
// Registers (sample*256 - bias) * rate_scale per axis.
// ============================================================================
module gbai_rmul (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  gbai_pkg::t_in_item                   i_item,
    input  logic                                 i_done,
    input  logic signed [gbai_pkg::BIAS_W-1:0]   i_bias [gbai_pkg::AXES],
    input  logic [gbai_pkg::SCALE_W-1:0]         i_scale,
    output gbai_pkg::t_s2_ctl                    o_ctl,
    output logic signed [gbai_pkg::PROD_W-1:0]   o_prod [gbai_pkg::AXES]
);
    import gbai_pkg::*;

    logic signed [RATE_W-1:0]    rate  [AXES];
    logic signed [DIFF_W-1:0]    diff  [AXES];
    logic signed [SCALE_W:0]     scale_s;
    logic signed [PROD_W:0]      prod  [AXES];
    logic signed [PROD_W-1:0]    r_prod [AXES];
    t_s2_ctl                     r_ctl;

    always_comb begin
        rate[0] = i_item.rate_x;
        rate[1] = i_item.rate_y;
        rate[2] = i_item.rate_z;
        scale_s = {1'b0, i_scale};
        for (int i = 0; i < AXES; i++) begin
            diff[i] = {rate[i][RATE_W-1], rate[i], {BIAS_FRAC{1'b0}}}
                    - {i_bias[i][BIAS_W-1], i_bias[i]};
            prod[i] = diff[i] * scale_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl.cmd  <= i_item.command;
            r_ctl.done <= i_done;
            for (int i = 0; i < AXES; i++) begin
                r_prod[i] <= prod[i][PROD_W-1:0];
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_prod = r_prod;

endmodule

/* hdl/gbai_accum.sv */
// ============================================================================
// gbai_accum - thresholded angle accumulators
// Floors the product to a Q.24 increment and, for integrate items, adds it when large enough.
// ============================================================================
module gbai_accum (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  gbai_pkg::t_s2_ctl                    i_ctl,
    input  logic signed [gbai_pkg::PROD_W-1:0]   i_prod [gbai_pkg::AXES],
    input  logic [gbai_pkg::THR_W-1:0]           i_thr,
    output gbai_pkg::t_out_item                  o_item
);
    import gbai_pkg::*;

    logic signed [INC_W-1:0]   inc   [AXES];
    logic [INC_W-1:0]          mag   [AXES];
    logic                      upd   [AXES];
    logic [ANGLE_W-1:0]        r_angle [AXES];
    logic                      r_done;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            // arithmetic shift floors toward minus infinity
            inc[i] = i_prod[i][PROD_W-1:INC_SHIFT];
            mag[i] = inc[i][INC_W-1] ? INC_W'(-inc[i]) : INC_W'(inc[i]);
            upd[i] = (i_ctl.cmd == CMD_INTEG) && (mag[i] >= INC_W'(i_thr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_angle[i] <= '0;
            end
        end else if (i_load) begin
            r_done <= i_ctl.done;
            for (int i = 0; i < AXES; i++) begin
                if (upd[i]) begin
                    r_angle[i] <= r_angle[i] + inc[i][ANGLE_W-1:0];
                end
            end
        end
    end

    assign o_item.angle_x_out      = r_angle[0];
    assign o_item.angle_y_out      = r_angle[1];
    assign o_item.angle_z_out      = r_angle[2];
    assign o_item.calibration_done = r_done;

endmodule

/* hdl/gyro_bias_angle_integrator_unit.sv */
// ============================================================================
// gyro_bias_angle_integrator_unit - gyro bias calibration and angle integrator
// Three-axis rate samples in; bias-corrected, scaled, thresholded angles out.
// ============================================================================
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | i_in_valid / o_in_stall  | i_in_item  (command, rate_x/y/z)
//  out     | o_out_valid / i_out_stall| o_out_item (angle_x/y/z_out, done)
//  cfg     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One item per cycle when neither the output stalls nor the bias divider
//  runs; three register stages: input, product, angle/output.
//  A completing calibration item starts the bias divider (a reciprocal
//  multiply); the input stage holds while the divider is busy.
//  Synchronous active-low reset clears angles, biases, sums, count, stage
//  valids and restores config defaults.
//  Each stage moves when the next one is empty or moving, so a stalled
//  output only backs up the stages behind it once they fill.
//
module gyro_bias_angle_integrator_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  gbai_pkg::t_in_item                    i_in_item,
    // result items
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output gbai_pkg::t_out_item                   o_out_item,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gbai_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gbai_pkg::SCALE_W-1:0]          i_cfg_data
);
    import gbai_pkg::*;

    // config registers
    logic [SCALE_W-1:0]        r_scale;
    logic [THR_W-1:0]          r_thr;

    // stage valids and input register
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    t_in_item                  r_s1;

    // stage advance
    logic                      en1;
    logic                      en2;
    logic                      en3;
    logic                      s1_go;
    logic                      s2_go;
    logic                      in_acc;

    t_cal_stat                 cal_stat;
    logic signed [BIAS_W-1:0]  bias  [AXES];
    logic signed [RATE_W-1:0]  s1_rate [AXES];
    t_s2_ctl                   s2_ctl;
    logic signed [PROD_W-1:0]  s2_prod [AXES];

    // --- flow control ------------------------------------------------------
    // the input stage also waits while new biases are being computed, so an
    // integrate item right behind a completed calibration sees fresh biases
    always_comb begin
        en3    = !r_v3 || !i_out_stall;
        en2    = !r_v2 || en3;
        s1_go  = r_v1 && en2 && !cal_stat.busy;
        s2_go  = r_v2 && en3;
        en1    = !r_v1 || s1_go;
        in_acc = i_in_valid && en1;
    end

    assign o_in_stall  = !en1;
    assign o_out_valid = r_v3;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end
            if (s1_go) begin
                r_v2 <= 1'b1;
            end else if (s2_go) begin
                r_v2 <= 1'b0;
            end
            if (s2_go) begin
                r_v3 <= 1'b1;
            end else if (!i_out_stall) begin
                r_v3 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_item;
        end
    end

    // --- configuration -----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= RATE_SCALE_RST;
            r_thr   <= HOLD_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RATE_SCALE:     r_scale <= i_cfg_data;
                CFG_HOLD_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // --- datapath ----------------------------------------------------------
    always_comb begin
        s1_rate[0] = r_s1.rate_x;
        s1_rate[1] = r_s1.rate_y;
        s1_rate[2] = r_s1.rate_z;
    end

    // calibration: sums update as the item leaves the input stage
    gbai_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (s1_go && (r_s1.command == CMD_CAL)),
        .i_rate  (s1_rate),
        .o_stat  (cal_stat),
        .o_bias  (bias)
    );

    // product stage
    gbai_rmul u_rmul (
        .i_clk   (i_clk),
        .i_load  (s1_go),
        .i_item  (r_s1),
        .i_done  (cal_stat.done),
        .i_bias  (bias),
        .i_scale (r_scale),
        .o_ctl   (s2_ctl),
        .o_prod  (s2_prod)
    );

    // angle accumulators double as the output register
    gbai_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s2_go),
        .i_ctl   (s2_ctl),
        .i_prod  (s2_prod),
        .i_thr   (r_thr),
        .o_item  (o_out_item)
    );

endmodule
